FILE: rtl/pcx_pkg.sv
package pcx_pkg;

  localparam int MAX_WIDTH_DEFAULT  = 4096;
  localparam int MAX_HEIGHT_DEFAULT = 4096;
  localparam int CMD_DEPTH          = 2;

  localparam logic [7:0]  RUN_MARK = 8'd192;
  localparam logic [12:0] ROW_MAX  = 13'd8191;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_PLANE_BYTES  = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_HEIGHT = 2'd1,
    ERR_TRUNC  = 2'd2
  } err_t;

  typedef enum logic {
    CMD_PLACE = 1'b0,
    CMD_TRUNC = 1'b1
  } cmd_kind_t;

  // One queued command: place data_byte count times, or report a cut-off run.
  typedef struct packed {
    cmd_kind_t   kind;
    logic        start;
    logic [5:0]  count;
    logic [7:0]  data;
  } cmd_t;

  typedef enum logic {
    BK_RUN   = 1'b0,
    BK_FLUSH = 1'b1
  } back_state_t;

endpackage

FILE: rtl/pcx_front.sv
module pcx_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    data_byte,
  input  logic          start_of_image,
  input  logic          end_of_data,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output pcx_pkg::cmd_t cmd
);

  logic       run_pending;
  logic [5:0] run_count;
  logic       run_pending_next;
  logic [5:0] run_count_next;
  logic       pending_eff;
  logic       is_marker;
  logic       accept;

  assign in_ready    = cmd_ready;
  assign accept      = in_valid & in_ready;
  assign pending_eff = run_pending & ~start_of_image;
  assign is_marker   = data_byte >= pcx_pkg::RUN_MARK;

  always_comb begin
    run_pending_next = run_pending;
    run_count_next   = run_count;
    cmd_valid        = 1'b0;
    cmd.kind         = pcx_pkg::CMD_PLACE;
    cmd.start        = start_of_image;
    cmd.count        = 6'd1;
    cmd.data         = data_byte;
    if (pending_eff) begin
      cmd_valid        = in_valid;
      cmd.count        = run_count;
      run_pending_next = 1'b0;
    end else if (is_marker) begin
      if (end_of_data) begin
        cmd_valid        = in_valid;
        cmd.kind         = pcx_pkg::CMD_TRUNC;
        run_pending_next = 1'b0;
      end else begin
        // A marker alone emits nothing, but a start flag must still reach the counters.
        cmd_valid        = in_valid & start_of_image;
        cmd.count        = 6'd0;
        run_pending_next = 1'b1;
        run_count_next   = data_byte[5:0];
      end
    end else begin
      cmd_valid        = in_valid;
      run_pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_pending <= 1'b0;
      run_count   <= 6'd0;
    end else if (accept) begin
      run_pending <= run_pending_next;
      run_count   <= run_count_next;
    end
  end

endmodule

FILE: rtl/pcx_cmd_fifo.sv
module pcx_cmd_fifo #(
  parameter int DEPTH = pcx_pkg::CMD_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  pcx_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop,
  output pcx_pkg::cmd_t pop_cmd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pcx_pkg::cmd_t    entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = fill != CW'(DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop & pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

FILE: rtl/pcx_back.sv
module pcx_back #(
  parameter int MAX_WIDTH  = pcx_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = pcx_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [12:0]   image_width,
  input  logic [12:0]   image_height,
  input  logic [13:0]   plane_bytes,
  input  logic          cmd_valid,
  output logic          cmd_pop,
  input  pcx_pkg::cmd_t cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    pixel_byte,
  output logic [25:0]   dest_address,
  output logic          last_of_item,
  output logic [1:0]    error_code
);

  pcx_pkg::back_state_t state;
  pcx_pkg::back_state_t state_next;

  logic [12:0] col;
  logic [1:0]  plane;
  logic [12:0] row;
  logic [27:0] row_prod;
  logic [25:0] row_base;
  logic [5:0]  step_idx;

  logic        held_valid;
  logic [7:0]  held_byte;
  logic [25:0] held_addr;
  logic [1:0]  held_err;

  logic [12:0] w_eff;
  logic [12:0] h_eff;
  logic [14:0] three_w;
  logic        can_out;
  logic        clr;
  logic [12:0] col_e;
  logic [1:0]  plane_e;
  logic [12:0] row_e;
  logic [25:0] row_base_e;
  logic        past;
  logic        made;
  logic [14:0] col3;
  logic [25:0] addr;
  logic [1:0]  err;
  logic [13:0] col_inc;
  logic        wrap;
  logic [12:0] col_adv;
  logic [1:0]  plane_adv;
  logic [12:0] row_adv;
  logic        last_step;

  logic        act;
  logic        push;
  logic [7:0]  push_byte;
  logic [25:0] push_addr;
  logic [1:0]  push_err;
  logic        push_last;
  logic        hold_load;
  logic        hold_clear;
  logic        cnt_clear;
  logic        cnt_adv;
  logic        step_inc;
  logic        step_reset;

  assign w_eff   = (32'(image_width) < 32'(MAX_WIDTH)) ? image_width : 13'(MAX_WIDTH);
  assign h_eff   = (32'(image_height) < 32'(MAX_HEIGHT)) ? image_height : 13'(MAX_HEIGHT);
  assign three_w = {2'b00, w_eff} + {1'b0, w_eff, 1'b0};
  assign can_out = ~out_valid | out_ready;

  // The row offset follows the current width, so it is formed from the row count.
  assign row_prod = 28'(row) * 28'(three_w);
  assign row_base = row_prod[25:0];

  // The start flag of a command clears the placement counters before its first byte.
  assign clr        = cmd.start & (step_idx == 6'd0);
  assign col_e      = clr ? 13'd0 : col;
  assign plane_e    = clr ? 2'd0 : plane;
  assign row_e      = clr ? 13'd0 : row;
  assign row_base_e = clr ? 26'd0 : row_base;

  assign past = row_e >= h_eff;
  assign made = past | (col_e < w_eff);
  assign col3 = {2'b00, col_e} + {1'b0, col_e, 1'b0};
  assign addr = past ? 26'd0 : row_base_e + 26'(col3) + 26'(2'd2 - plane_e);
  assign err  = past ? pcx_pkg::ERR_HEIGHT : pcx_pkg::ERR_OK;

  assign col_inc = {1'b0, col_e} + 14'd1;
  assign wrap    = (col_inc >= plane_bytes) | col_inc[13];

  always_comb begin
    col_adv   = wrap ? 13'd0 : col_inc[12:0];
    plane_adv = plane_e;
    row_adv   = row_e;
    if (wrap) begin
      if (plane_e >= 2'd2) begin
        plane_adv = 2'd0;
        if (row_e < pcx_pkg::ROW_MAX) begin
          row_adv = row_e + 13'd1;
        end
      end else begin
        plane_adv = plane_e + 2'd1;
      end
    end
  end

  assign last_step = step_idx == (cmd.count - 6'd1);
  assign act       = (state == pcx_pkg::BK_RUN) & cmd_valid & can_out;

  always_comb begin
    state_next = state;
    case (state)
      pcx_pkg::BK_RUN: begin
        if (act && cmd.kind == pcx_pkg::CMD_PLACE && cmd.count != 6'd0 && last_step &&
            made && held_valid) begin
          state_next = pcx_pkg::BK_FLUSH;
        end
      end
      pcx_pkg::BK_FLUSH: begin
        if (can_out) begin
          state_next = pcx_pkg::BK_RUN;
        end
      end
      default: state_next = pcx_pkg::BK_RUN;
    endcase
  end

  // A made result waits in the held register until it is known whether it is
  // the item's final one.
  always_comb begin
    cmd_pop    = 1'b0;
    push       = 1'b0;
    push_byte  = held_byte;
    push_addr  = held_addr;
    push_err   = held_err;
    push_last  = 1'b0;
    hold_load  = 1'b0;
    hold_clear = 1'b0;
    cnt_clear  = 1'b0;
    cnt_adv    = 1'b0;
    step_inc   = 1'b0;
    step_reset = 1'b0;
    case (state)
      pcx_pkg::BK_RUN: begin
        if (act) begin
          if (cmd.kind == pcx_pkg::CMD_TRUNC) begin
            push      = 1'b1;
            push_byte = 8'd0;
            push_addr = 26'd0;
            push_err  = pcx_pkg::ERR_TRUNC;
            push_last = 1'b1;
            cmd_pop   = 1'b1;
            cnt_clear = clr;
          end else if (cmd.count == 6'd0) begin
            cmd_pop   = 1'b1;
            cnt_clear = clr;
          end else begin
            cnt_adv = 1'b1;
            if (last_step) begin
              cmd_pop    = 1'b1;
              step_reset = 1'b1;
            end else begin
              step_inc = 1'b1;
            end
            if (made && held_valid) begin
              push      = 1'b1;
              hold_load = 1'b1;
            end else if (made) begin
              if (last_step) begin
                push      = 1'b1;
                push_byte = cmd.data;
                push_addr = addr;
                push_err  = err;
                push_last = 1'b1;
              end else begin
                hold_load = 1'b1;
              end
            end else if (held_valid && last_step) begin
              push       = 1'b1;
              push_last  = 1'b1;
              hold_clear = 1'b1;
            end
          end
        end
      end
      pcx_pkg::BK_FLUSH: begin
        if (can_out) begin
          push       = 1'b1;
          push_last  = 1'b1;
          hold_clear = 1'b1;
        end
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pcx_pkg::BK_RUN;
      col        <= 13'd0;
      plane      <= 2'd0;
      row        <= 13'd0;
      step_idx   <= 6'd0;
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cnt_clear) begin
        col   <= 13'd0;
        plane <= 2'd0;
        row   <= 13'd0;
      end else if (cnt_adv) begin
        col   <= col_adv;
        plane <= plane_adv;
        row   <= row_adv;
      end
      if (step_reset) begin
        step_idx <= 6'd0;
      end else if (step_inc) begin
        step_idx <= step_idx + 6'd1;
      end
      if (hold_load) begin
        held_valid <= 1'b1;
      end else if (hold_clear) begin
        held_valid <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hold_load) begin
      held_byte <= cmd.data;
      held_addr <= addr;
      held_err  <= err;
    end
    if (push) begin
      pixel_byte   <= push_byte;
      dest_address <= push_addr;
      error_code   <= push_err;
      last_of_item <= push_last;
    end
  end

endmodule

FILE: rtl/pcx_rle_planar_decoder_core.sv
// Registers: an accepted literal's result passes through the two-entry command queue
// and then the output register; a kept byte of a run waits in a hold register
// until the next kept byte or the end of its run.
// Throughput: one placed byte per cycle from the back end while the output is not
// stalled; a run whose last byte is kept after an earlier kept one adds a BK_FLUSH step.
// Synchronous active-high reset clears the counters, queue and pending run, and sets
// all three configuration registers to 1.
module pcx_rle_planar_decoder_core #(
  parameter int MAX_WIDTH  = pcx_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = pcx_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        start_of_image,
  input  logic        end_of_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  pixel_byte,
  output logic [25:0] dest_address,
  output logic        last_of_item,
  output logic [1:0]  error_code
);

  logic [12:0]   image_width;
  logic [12:0]   image_height;
  logic [13:0]   plane_bytes;
  logic          push_valid;
  logic          push_ready;
  pcx_pkg::cmd_t push_cmd;
  logic          head_valid;
  logic          head_pop;
  pcx_pkg::cmd_t head_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd1;
      image_height <= 13'd1;
      plane_bytes  <= 14'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        pcx_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data[12:0];
        pcx_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
        pcx_pkg::CFG_PLANE_BYTES:  plane_bytes  <= cfg_data;
        default: ;
      endcase
    end
  end

  pcx_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .start_of_image (start_of_image),
    .end_of_data    (end_of_data),
    .cmd_valid      (push_valid),
    .cmd_ready      (push_ready),
    .cmd            (push_cmd)
  );

  pcx_cmd_fifo #(
    .DEPTH (pcx_pkg::CMD_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (head_valid),
    .pop        (head_pop),
    .pop_cmd    (head_cmd)
  );

  pcx_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .plane_bytes  (plane_bytes),
    .cmd_valid    (head_valid),
    .cmd_pop      (head_pop),
    .cmd          (head_cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_byte   (pixel_byte),
    .dest_address (dest_address),
    .last_of_item (last_of_item),
    .error_code   (error_code)
  );

endmodule
